>>> hdl/rkfrd_pkg.sv
// Package for the remote key frame repeat decoder.
// Holds the widths, frame constants, register indexes and event codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rkfrd_pkg;

    localparam int FRAME_BYTES = 6;
    localparam int KEY_W       = 8 * FRAME_BYTES;
    localparam int ADDR_W      = 16;
    localparam int CMD_W       = 32;
    localparam int TIME_W      = 16;
    localparam int CNT_W       = 3;
    localparam int CFG_IDX_W   = 2;

    localparam logic [7:0]        START_BYTE     = 8'h58;
    localparam logic [7:0]        FILLER_CODE    = 8'd66;
    localparam logic [ADDR_W-1:0] FILLER_ADDRESS = 16'h0000;
    localparam logic [CMD_W-1:0]  FILLER_COMMAND = 32'h0000_4000;
    localparam logic [TIME_W-1:0] TIME_MAX       = 16'hFFFF;

    localparam logic [TIME_W-1:0] REPEAT_DELAY_RST = 16'd350;
    localparam logic [TIME_W-1:0] REPEAT_LIMIT_RST = 16'd150;
    localparam logic [TIME_W-1:0] BYTE_TIMEOUT_RST = 16'd20;

    localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(FRAME_BYTES);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_CODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_TIMEOUT = 2'd3;

    // Event kinds carried in s_tuser.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

endpackage

`default_nettype wire

>>> hdl/remote_key_frame_repeat_decoder.sv
// Top level of the remote key frame repeat decoder.
// Depends on rkfrd_pkg for constants and register indexes.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one event per transfer on the s_ side: a received byte or a
// millisecond tick (s_tuser selects which). Key frames are 'X' followed by a
// 16-bit address and a 32-bit command, big-endian. New keys, delayed repeats
// and releases of repeating keys come out on the m_ side, at most one per event.
// An event is taken into an input register and decoded from there into the
// result register, so the sustained rate is one event per clock while no result
// waits on m_tready. A waiting result stalls decoding, and the input register
// then holds one more event. The user must write configuration registers through
// cfg_* only while no event is pending; the block itself does not enforce this.
module remote_key_frame_repeat_decoder
    import rkfrd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] rx_byte
    input  wire logic                 s_tuser,   // [0] op
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [KEY_W-1:0]          m_tdata,   // [15:0] key_address, [47:16] key_command
    output logic [1:0]                m_tuser,   // [0] is_repeat, [1] is_release
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [TIME_W-1:0]    cfg_data
);

    // Configuration.
    logic [7:0]        device_code_reg;
    logic [TIME_W-1:0] repeat_delay_reg;
    logic [TIME_W-1:0] repeat_limit_reg;
    logic [TIME_W-1:0] byte_timeout_reg;

    // Input register.
    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;

    // Decoder state.
    logic              in_frame_reg,       in_frame_next;
    logic [CNT_W-1:0]  count_reg,          count_next;
    logic [KEY_W-1:0]  shift_reg,          shift_next;
    logic [KEY_W-1:0]  last_key_reg,       last_key_next;
    logic              last_valid_reg,     last_valid_next;
    logic              repeating_reg,      repeating_next;
    logic [TIME_W-1:0] press_reg,          press_next;
    logic [TIME_W-1:0] idle_reg,           idle_next;

    // Result register.
    logic              out_valid_reg,      out_valid_next;
    logic [KEY_W-1:0]  out_key_reg,        out_key_next;
    logic              out_rep_reg,        out_rep_next;
    logic              out_rel_reg,        out_rel_next;

    logic              advance;
    logic              emit;
    logic [TIME_W-1:0] press_inc;
    logic [TIME_W-1:0] idle_inc;
    logic [CNT_W-1:0]  count_inc;
    logic [KEY_W-1:0]  shift_in;
    logic              filler;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign press_inc = (press_reg == TIME_MAX) ? press_reg : press_reg + 1'b1;
    assign idle_inc  = (idle_reg == TIME_MAX) ? idle_reg : idle_reg + 1'b1;
    assign count_inc = count_reg + 1'b1;
    assign shift_in  = {shift_reg[KEY_W-9:0], in_byte_reg};
    assign filler    = (device_code_reg == FILLER_CODE)
                    && (shift_in[KEY_W-1 -: ADDR_W] == FILLER_ADDRESS)
                    && (shift_in[CMD_W-1:0] == FILLER_COMMAND);

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        count_next      = count_reg;
        shift_next      = shift_reg;
        last_key_next   = last_key_reg;
        last_valid_next = last_valid_reg;
        repeating_next  = repeating_reg;
        press_next      = press_reg;
        idle_next       = idle_reg;
        emit            = 1'b0;
        out_key_next    = out_key_reg;
        out_rep_next    = out_rep_reg;
        out_rel_next    = out_rel_reg;

        if (in_op_reg == OP_TICK)
        begin
            press_next = press_inc;
            idle_next  = idle_inc;
            if (in_frame_reg)
            begin
                // A stalled frame is dropped; the last key survives.
                if (idle_inc >= byte_timeout_reg)
                begin
                    in_frame_next = 1'b0;
                    count_next    = '0;
                    idle_next     = '0;
                end
            end
            else if (idle_inc >= repeat_limit_reg)
            begin
                emit            = repeating_reg;
                out_key_next    = last_key_reg;
                out_rep_next    = 1'b0;
                out_rel_next    = 1'b1;
                repeating_next  = 1'b0;
                last_valid_next = 1'b0;
                idle_next       = '0;
            end
        end
        else if (in_frame_reg)
        begin
            shift_next = shift_in;
            count_next = count_inc;
            idle_next  = '0;
            if (count_inc >= LAST_COUNT)
            begin
                in_frame_next = 1'b0;
                count_next    = '0;
                if (!filler)
                begin
                    if (!last_valid_reg || shift_in != last_key_reg)
                    begin
                        last_key_next   = shift_in;
                        last_valid_next = 1'b1;
                        repeating_next  = 1'b0;
                        press_next      = '0;
                        emit            = 1'b1;
                        out_key_next    = shift_in;
                        out_rep_next    = 1'b0;
                        out_rel_next    = 1'b0;
                    end
                    else if (press_reg >= repeat_delay_reg)
                    begin
                        repeating_next = 1'b1;
                        emit           = 1'b1;
                        out_key_next   = shift_in;
                        out_rep_next   = 1'b1;
                        out_rel_next   = 1'b0;
                    end
                end
            end
        end
        else if (in_byte_reg == START_BYTE)
        begin
            in_frame_next = 1'b1;
            count_next    = '0;
            shift_next    = '0;
            idle_next     = '0;
        end
        else
        begin
            emit            = repeating_reg;
            out_key_next    = last_key_reg;
            out_rep_next    = 1'b0;
            out_rel_next    = 1'b1;
            repeating_next  = 1'b0;
            last_valid_next = 1'b0;
            idle_next       = '0;
        end
    end

    always_comb
    begin
        if (advance)
            out_valid_next = emit;
        else
            out_valid_next = out_valid_reg && !m_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_code_reg  <= '0;
            repeat_delay_reg <= REPEAT_DELAY_RST;
            repeat_limit_reg <= REPEAT_LIMIT_RST;
            byte_timeout_reg <= BYTE_TIMEOUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DEVICE_CODE:  device_code_reg  <= cfg_data[7:0];
                REG_REPEAT_DELAY: repeat_delay_reg <= cfg_data;
                REG_REPEAT_LIMIT: repeat_limit_reg <= cfg_data;
                REG_BYTE_TIMEOUT: byte_timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            in_frame_reg   <= 1'b0;
            count_reg      <= '0;
            shift_reg      <= '0;
            last_key_reg   <= '0;
            last_valid_reg <= 1'b0;
            repeating_reg  <= 1'b0;
            press_reg      <= '0;
            idle_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                in_frame_reg   <= in_frame_next;
                count_reg      <= count_next;
                shift_reg      <= shift_next;
                last_key_reg   <= last_key_next;
                last_valid_reg <= last_valid_next;
                repeating_reg  <= repeating_next;
                press_reg      <= press_next;
                idle_reg       <= idle_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (advance && emit)
        begin
            out_key_reg <= out_key_next;
            out_rep_reg <= out_rep_next;
            out_rel_reg <= out_rel_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_key_reg[CMD_W-1:0], out_key_reg[KEY_W-1 -: ADDR_W]};
    assign m_tuser  = {out_rel_reg, out_rep_reg};

endmodule

`default_nettype wire

>>> tb/sv/remote_key_frame_repeat_decoder_tb.sv
// Self-checking testbench for the remote key frame repeat decoder.
// Predicts key, repeat and release events from the byte and tick stream and checks them.
// Depends on rkfrd_pkg and the remote_key_frame_repeat_decoder RTL.
`timescale 1ns / 1ps

module remote_key_frame_repeat_decoder_tb;
    import rkfrd_pkg::*;

    // Even with the longest gaps and stalls on every event, a correct run stays
    // well under this limit.
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [CMD_W-1:0]  cmd;
        logic              rep;
        logic              rel;
    } key_event_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [KEY_W-1:0]     m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TIME_W-1:0]    cfg_data  = '0;

    remote_key_frame_repeat_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Decoder settings as last written.
    logic [7:0]        dev_code  = 8'd0;
    logic [TIME_W-1:0] rpt_delay = REPEAT_DELAY_RST;
    logic [TIME_W-1:0] rpt_limit = REPEAT_LIMIT_RST;
    logic [TIME_W-1:0] byte_to   = BYTE_TIMEOUT_RST;

    // Decoder state as predicted.
    logic              in_frame    = 1'b0;
    logic [CNT_W-1:0]  frame_cnt   = '0;
    logic [KEY_W-1:0]  frame_shift = '0;
    logic [KEY_W-1:0]  last_key    = '0;
    logic              key_held    = 1'b0;
    logic              repeating   = 1'b0;
    logic [TIME_W-1:0] press_ms    = '0;
    logic [TIME_W-1:0] idle_ms     = '0;

    key_event_t expected_events[$];

    int  mismatches  = 0;
    int  cycle_count = 0;
    int  sent_items  = 0;
    int  stall_left  = 0;
    bit  no_gaps     = 1'b0;
    key_event_t event_seen;
    key_event_t event_want;

    function automatic void record_event(logic [KEY_W-1:0] key, logic rep, logic rel);
        key_event_t ev;
        ev.addr = key[KEY_W-1:CMD_W];
        ev.cmd  = key[CMD_W-1:0];
        ev.rep  = rep;
        ev.rel  = rel;
        expected_events.push_back(ev);
    endfunction

    // A hold ends on an idle byte that is not a frame start, or on the idle limit.
    function automatic void end_key_hold();
        if (repeating)
            record_event(last_key, 1'b0, 1'b1);
        repeating = 1'b0;
        key_held  = 1'b0;
        idle_ms   = '0;
    endfunction

    function automatic void decode_event(logic op, logic [7:0] rx);
        logic [KEY_W-1:0] key;
        logic             filler;
        if (op == OP_TICK)
        begin
            if (press_ms != TIME_MAX)
                press_ms++;
            if (idle_ms != TIME_MAX)
                idle_ms++;
            if (in_frame)
            begin
                if (idle_ms >= byte_to)
                begin
                    in_frame  = 1'b0;
                    frame_cnt = '0;
                    idle_ms   = '0;
                end
            end
            else if (idle_ms >= rpt_limit)
            begin
                end_key_hold();
            end
        end
        else if (in_frame)
        begin
            // Every byte inside a frame is data, a start byte included.
            frame_shift = {frame_shift[KEY_W-9:0], rx};
            frame_cnt++;
            idle_ms = '0;
            if (frame_cnt >= LAST_COUNT)
            begin
                key       = frame_shift;
                in_frame  = 1'b0;
                frame_cnt = '0;
                filler    = (dev_code == FILLER_CODE)
                            && (key[KEY_W-1:CMD_W] == FILLER_ADDRESS)
                            && (key[CMD_W-1:0] == FILLER_COMMAND);
                if (!filler)
                begin
                    if (!key_held || key != last_key)
                    begin
                        last_key  = key;
                        key_held  = 1'b1;
                        repeating = 1'b0;
                        press_ms  = '0;
                        record_event(key, 1'b0, 1'b0);
                    end
                    else if (press_ms >= rpt_delay)
                    begin
                        repeating = 1'b1;
                        record_event(key, 1'b1, 1'b0);
                    end
                end
            end
        end
        else if (rx == START_BYTE)
        begin
            in_frame    = 1'b1;
            frame_cnt   = '0;
            frame_shift = '0;
            idle_ms     = '0;
        end
        else
        begin
            end_key_hold();
        end
    endfunction

    // Mostly no gap, sometimes a short one, rarely a long one; never one while no_gaps is set.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps)
            return 0;
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_event(logic op, logic [7:0] rx);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= rx;
        do
            @(posedge clk);
        while (!s_tready);
        decode_event(op, rx);
        sent_items++;
        @(negedge clk);
    endtask

    task automatic send_ticks(int count);
        repeat (count) send_event(OP_TICK, 8'($urandom));
    endtask

    // Start byte, then address and command, most significant byte first; with_ticks puts random ticks between bytes.
    task automatic send_frame(logic [KEY_W-1:0] key, bit with_ticks);
        int lim;
        send_event(OP_BYTE, START_BYTE);
        for (int i = FRAME_BYTES - 1; i >= 0; i--)
        begin
            if (with_ticks && byte_to > 1 && $urandom_range(0, 2) == 0)
            begin
                lim = (byte_to > 9) ? 8 : byte_to - 1;
                send_ticks($urandom_range(0, lim));
            end
            send_event(OP_BYTE, key[8*i +: 8]);
        end
    endtask

    // Waits until every expected event is in and the pipeline has emptied.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_events.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_DEVICE_CODE:  dev_code  = val[7:0];
            REG_REPEAT_DELAY: rpt_delay = val;
            REG_REPEAT_LIMIT: rpt_limit = val;
            REG_BYTE_TIMEOUT: byte_to   = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic write_settings(logic [7:0] code, logic [TIME_W-1:0] dly,
                                  logic [TIME_W-1:0] lim, logic [TIME_W-1:0] tmo);
        drain();
        put_reg(REG_DEVICE_CODE, {8'h00, code});
        put_reg(REG_REPEAT_DELAY, dly);
        put_reg(REG_REPEAT_LIMIT, lim);
        put_reg(REG_BYTE_TIMEOUT, tmo);
        cfg_valid <= 1'b0;
    endtask

    // Reset settings; the command holds a start byte as frame data.
    task automatic test_first_key_defaults();
        send_frame(48'h0000_5800_0000, 1'b0);
    endtask

    task automatic test_repeat_and_release();
        write_settings(FILLER_CODE, 16'd2, 16'd3, 16'd2);
        send_frame(48'hFFFF_FFFF_FFFF, 1'b0);
        send_ticks(2);
        send_frame(48'hFFFF_FFFF_FFFF, 1'b0);
        send_event(OP_BYTE, 8'h00);
    endtask

    task automatic test_filler_drop();
        send_frame({FILLER_ADDRESS, FILLER_COMMAND}, 1'b0);
    endtask

    // Release on the idle limit, then a frame abandoned on the byte timeout.
    task automatic test_timeouts();
        write_settings(8'hFF, 16'd1, 16'd3, 16'd1);
        send_frame(48'h0123_4567_89AB, 1'b0);
        send_ticks(1);
        send_frame(48'h0123_4567_89AB, 1'b0);
        send_ticks(3);
        send_event(OP_BYTE, START_BYTE);
        send_event(OP_BYTE, 8'h12);
        send_ticks(1);
    endtask

    // Largest settings: a held key is neither repeated nor released by idle time.
    task automatic test_long_hold();
        logic [KEY_W-1:0] key;
        key = 48'hA5A5_0F0F_C3C3;
        write_settings(FILLER_CODE, TIME_MAX, TIME_MAX, TIME_MAX);
        send_frame(key, 1'b1);
        send_ticks(60);
        // Same key before the delay is dropped but restarts the idle time.
        send_frame(key, 1'b0);
        send_ticks(40);
        send_frame(key, 1'b0);
        send_event(OP_BYTE, 8'h00);
    endtask

    task automatic run_traffic(int count);
        logic [KEY_W-1:0] pool [3];
        int start;
        int r;
        int cap;
        pool[0] = {16'($urandom), 32'($urandom)};
        pool[1] = {16'($urandom), 32'($urandom)};
        pool[2] = {FILLER_ADDRESS, FILLER_COMMAND};
        start   = sent_items;
        while (sent_items - start < count)
        begin
            r   = $urandom_range(0, 99);
            cap = (rpt_limit > 40) ? 40 : rpt_limit;
            if (r < 55)
            begin
                send_frame(pool[$urandom_range(0, 2)], $urandom_range(0, 3) == 0);
                send_ticks($urandom_range(0, cap));
            end
            else if (r < 70)
            begin
                send_ticks($urandom_range(0, cap + 3));
            end
            else if (r < 80)
            begin
                send_event(OP_BYTE, 8'($urandom));
            end
            else if (r < 90)
            begin
                // Truncated frame, then enough ticks to abandon it where the timeout allows.
                send_event(OP_BYTE, START_BYTE);
                repeat ($urandom_range(0, 4)) send_event(OP_BYTE, 8'($urandom));
                send_ticks((byte_to > 40) ? 40 : byte_to);
            end
            else
            begin
                send_frame({16'($urandom), 32'($urandom)}, 1'b0);
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [TIME_W-1:0] dly;
        for (int p = 0; p < 10; p++)
        begin
            no_gaps = (p == 3 || p == 7);
            dly     = 16'($urandom_range(1, 20));
            if (p == 0)
                write_settings(FILLER_CODE, 16'd1, 16'd1, 16'd1);
            else if (p == 1)
                write_settings(8'd0, TIME_MAX, TIME_MAX, TIME_MAX);
            else
                write_settings(($urandom_range(0, 1) == 1) ? FILLER_CODE : 8'($urandom),
                               dly, dly + 16'($urandom_range(3, 30)),
                               16'($urandom_range(1, 12)));
            run_traffic(100);
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_first_key_defaults();
        test_repeat_and_release();
        test_filler_drop();
        test_timeouts();
        test_long_hold();
        test_random_traffic();
        drain();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Result side stalls.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            stall_left = pick_gap();
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            event_seen.addr = m_tdata[ADDR_W-1:0];
            event_seen.cmd  = m_tdata[KEY_W-1:ADDR_W];
            event_seen.rep  = m_tuser[0];
            event_seen.rel  = m_tuser[1];
            if (expected_events.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected event: addr %h cmd %h repeat %b release %b",
                             event_seen.addr, event_seen.cmd, event_seen.rep, event_seen.rel);
            end
            else
            begin
                event_want = expected_events.pop_front();
                if (event_seen.addr !== event_want.addr || event_seen.cmd !== event_want.cmd
                    || event_seen.rep !== event_want.rep || event_seen.rel !== event_want.rel)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"event mismatch: want addr %h cmd %h rep %b rel %b, ",
                                  "got addr %h cmd %h rep %b rel %b"},
                                 event_want.addr, event_want.cmd, event_want.rep,
                                 event_want.rel, event_seen.addr, event_seen.cmd,
                                 event_seen.rep, event_seen.rel);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

>>> filelist.f
hdl/rkfrd_pkg.sv
hdl/remote_key_frame_repeat_decoder.sv
tb/sv/remote_key_frame_repeat_decoder_tb.sv
